FILE: rtl/core/ptrs_pkg.sv
`timescale 1ns / 1ps

package ptrs_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int CODE_BITS_DEF   = 3;

    // fixed field widths of the item and result, and width of the entry count
    localparam int IDX_W  = 10;
    localparam int CODE_W = 3;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 11'd1024;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SEARCH = 2'd1,
        OP_EXISTS = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_RANGE_ERR = 2'd2,
        ST_WRITTEN   = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode           opcode;
        logic [IDX_W-1:0]  range_start;
        logic [IDX_W-1:0]  range_end;
        logic [CODE_W-1:0] progress_code;
        logic              match_equal;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] found_index;
    } t_result;

endpackage

FILE: rtl/core/ptrs_table.sv
`timescale 1ns / 1ps

module ptrs_table
    import ptrs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int CODE_BITS   = CODE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0] i_wr_addr,
    input  logic [CODE_BITS-1:0]           i_wr_data,
    input  logic [$clog2(MAX_ENTRIES)-1:0] i_rd_addr,
    output logic [CODE_BITS-1:0]           o_rd_data,
    output logic                           o_clearing
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam logic [IW-1:0] LAST_ADDR = IW'(MAX_ENTRIES - 1);

    logic [CODE_BITS-1:0] r_mem [MAX_ENTRIES];
    logic [CODE_BITS-1:0] r_rd_data;
    logic [IW-1:0]        r_clr_addr;
    logic                 r_clearing;

    // zero sweep after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

FILE: rtl/core/ptrs_seq.sv
`timescale 1ns / 1ps

module ptrs_seq
    import ptrs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int CODE_BITS   = CODE_BITS_DEF,
    parameter int NW          = CNT_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  t_item                          i_item,
    input  logic [NW-1:0]                  i_live_cnt,
    input  logic                           i_clearing,
    output logic                           o_busy,
    output logic                           o_done,
    output t_result                        o_result,
    output logic                           o_wr_en,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_wr_addr,
    output logic [CODE_BITS-1:0]           o_wr_data,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_rd_addr,
    input  logic [CODE_BITS-1:0]           i_rd_data
);

    localparam int IW = $clog2(MAX_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state               r_state;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_last;
    logic                 r_back;
    logic [CODE_BITS-1:0] r_code;
    logic                 r_match_eq;
    logic                 r_chk_valid;
    logic [IW-1:0]        r_chk_idx;
    logic                 r_chk_last;
    logic                 r_done;
    t_result              r_result;

    logic                        take;
    logic [NW-1:0]               start_ext;
    logic [NW-1:0]               end_ext;
    logic                        start_bad;
    logic                        end_bad;
    logic [IW+IDX_W-1:0]         start_wide;
    logic [IW+IDX_W-1:0]         end_wide;
    logic [IW-1:0]               start_idx;
    logic [IW-1:0]               end_idx;
    logic [NW-1:0]               live_m1;
    logic [CODE_BITS+CODE_W-1:0] code_wide;
    logic [CODE_BITS-1:0]        code_in;
    logic [IW+IDX_W-1:0]         fidx_wide;
    logic                        hit;

    assign o_busy = i_clearing || (r_state != S_IDLE);
    assign take   = i_start && !o_busy;

    assign start_ext  = NW'(i_item.range_start);
    assign end_ext    = NW'(i_item.range_end);
    assign start_bad  = start_ext >= i_live_cnt;
    assign end_bad    = end_ext >= i_live_cnt;
    assign start_wide = {{IW{1'b0}}, i_item.range_start};
    assign end_wide   = {{IW{1'b0}}, i_item.range_end};
    assign start_idx  = start_wide[IW-1:0];
    assign end_idx    = end_wide[IW-1:0];
    assign live_m1    = i_live_cnt - 1'b1;
    assign code_wide  = {{CODE_BITS{1'b0}}, i_item.progress_code};
    assign code_in    = code_wide[CODE_BITS-1:0];
    assign fidx_wide  = {{IDX_W{1'b0}}, r_chk_idx};

    // compare unit on the registered table read
    assign hit = ((i_rd_data == r_code) == r_match_eq);

    assign o_wr_en   = take && (i_item.opcode == OP_WRITE) && !start_bad;
    assign o_wr_addr = start_idx;
    assign o_wr_data = code_in;
    assign o_rd_addr = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_chk_valid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_code      <= code_in;
                        r_match_eq  <= i_item.match_equal;
                        r_chk_valid <= 1'b0;
                        unique case (i_item.opcode)
                            OP_WRITE: begin
                                r_done               <= 1'b1;
                                r_result.status      <= start_bad ? ST_RANGE_ERR : ST_WRITTEN;
                                r_result.found_index <= '0;
                            end
                            OP_SEARCH: begin
                                if (start_bad || end_bad) begin
                                    r_done               <= 1'b1;
                                    r_result.status      <= ST_RANGE_ERR;
                                    r_result.found_index <= '0;
                                end else begin
                                    r_idx   <= start_idx;
                                    r_last  <= end_idx;
                                    r_back  <= end_idx < start_idx;
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_EXISTS: begin
                                if (i_live_cnt == '0) begin
                                    r_done               <= 1'b1;
                                    r_result.status      <= ST_NOT_FOUND;
                                    r_result.found_index <= '0;
                                end else begin
                                    // highest entry in use first
                                    r_idx   <= live_m1[IW-1:0];
                                    r_last  <= '0;
                                    r_back  <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_done               <= 1'b1;
                                r_result.status      <= ST_RANGE_ERR;
                                r_result.found_index <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // issue the next read while checking the one before
                    r_chk_valid <= 1'b1;
                    r_chk_idx   <= r_idx;
                    r_chk_last  <= (r_idx == r_last);
                    r_idx       <= r_back ? r_idx - 1'b1 : r_idx + 1'b1;
                    if (r_chk_valid && (hit || r_chk_last)) begin
                        r_done               <= 1'b1;
                        r_result.status      <= hit ? ST_FOUND : ST_NOT_FOUND;
                        r_result.found_index <= hit ? fidx_wide[IDX_W-1:0] : '0;
                        r_chk_valid          <= 1'b0;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_no_done_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clearing |-> !o_done)
        else $error("result strobe during table clear");

    a_write_not_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !i_clearing)
        else $error("table write while clearing");

    a_take_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_done || r_state == S_SCAN))
        else $error("accepted item neither answered nor scanning");

    a_found_has_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.status == ST_FOUND) |-> $past(r_chk_valid && hit))
        else $error("found reported without a compare hit");

    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("busy while result is shown");

endmodule

FILE: rtl/core/progress_table_range_search.sv
`timescale 1ns / 1ps

// channel   | signals                       | transfer
// ----------+-------------------------------+--------------------------------
// item in   | start, busy, i_item           | rising edge with start && !busy
// result    | o_done, o_result              | every cycle o_done is high
// config    | i_cfg_we, i_cfg_wdata         | rising edge with i_cfg_we
//
// write, range error, bad opcode and empty exists: result in the cycle after transfer.
// search and exists: result registered once the check hits or reaches the last entry,
// limited by the single read port of the table (one entry a cycle).
// reset: zero sweep of all MAX_ENTRIES table entries with busy high; config writes
// are taken during it. the receiver cannot stall: each result is shown one cycle.

module progress_table_range_search
    import ptrs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int CODE_BITS   = CODE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    output logic             o_done,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int NW = (CW > CNT_W) ? CW : CNT_W;

    logic [CNT_W-1:0]     r_entry_count;
    logic [NW-1:0]        cnt_ext;
    logic [NW-1:0]        max_cnt;
    logic [NW-1:0]        live_cnt;
    logic                 clearing;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [CODE_BITS-1:0] wr_data;
    logic [IW-1:0]        rd_addr;
    logic [CODE_BITS-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= ENTRY_COUNT_RST;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // counts above the table size act as the table size
    assign cnt_ext  = NW'(r_entry_count);
    assign max_cnt  = NW'(MAX_ENTRIES);
    assign live_cnt = (cnt_ext < max_cnt) ? cnt_ext : max_cnt;

    ptrs_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CODE_BITS   (CODE_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .o_clearing (clearing)
    );

    ptrs_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CODE_BITS   (CODE_BITS),
        .NW          (NW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .i_live_cnt (live_cnt),
        .i_clearing (clearing),
        .o_busy     (busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

endmodule
